### design/opa_pkg.sv
// opa_pkg: shared widths, angle constants and pipeline record types
// for the octant pseudo-angle block. No dependencies.
package opa_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;

    // difference of two coordinates, and its magnitude
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int MAG_W  = COORD_BITS + 1;

    // 45 degrees in fixed point, and the quotient width it implies
    localparam int SCALE = 45 * (2 ** FRAC_BITS);
    localparam int Q_W   = $clog2(SCALE + 1);
    localparam int NUM_W = MAG_W + Q_W;

    localparam int BEARING_W = 17;

    localparam logic [BEARING_W-1:0] DEG_0   = '0;
    localparam logic [BEARING_W-1:0] DEG_90  = BEARING_W'(90 * (2 ** FRAC_BITS));
    localparam logic [BEARING_W-1:0] DEG_180 = BEARING_W'(180 * (2 ** FRAC_BITS));
    localparam logic [BEARING_W-1:0] DEG_270 = BEARING_W'(270 * (2 ** FRAC_BITS));
    localparam logic [BEARING_W-1:0] DEG_360 = BEARING_W'(360 * (2 ** FRAC_BITS));

    // octant result: base plus or minus the quotient
    typedef struct packed {
        logic                 neg;
        logic [BEARING_W-1:0] base;
    } opa_ctrl_t;

    // one slot of the divider chain
    typedef struct packed {
        logic             valid;
        opa_ctrl_t        ctrl;
        logic [MAG_W-1:0] rem;
        logic [Q_W-1:0]   low;
        logic [MAG_W-1:0] div;
        logic [Q_W-1:0]   quot;
    } opa_div_t;

endpackage

### design/opa_octant.sv
// opa_octant: coordinate differences, octant selection and the scaled
// numerator feeding the divider chain. Depends on opa_pkg.
module opa_octant (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req,
    input  logic signed [opa_pkg::COORD_BITS-1:0] from_x,
    input  logic signed [opa_pkg::COORD_BITS-1:0] from_z,
    input  logic signed [opa_pkg::COORD_BITS-1:0] to_x,
    input  logic signed [opa_pkg::COORD_BITS-1:0] to_z,
    output opa_pkg::opa_div_t                   div_o
);
    import opa_pkg::*;

    logic                     va_reg;
    logic signed [DIFF_W-1:0] dx_reg, dz_reg;
    logic signed [DIFF_W-1:0] dx_next, dz_next;

    logic             vb_reg;
    logic [MAG_W-1:0] n_reg, d_reg, n_next, d_next;
    opa_ctrl_t        ctrl_reg, ctrl_next;

    logic [MAG_W-1:0] a, b;
    logic [NUM_W-1:0] num;
    opa_div_t         div_reg, div_next;

    // stage A: exact differences
    assign dx_next = DIFF_W'(to_x) - DIFF_W'(from_x);
    assign dz_next = DIFF_W'(to_z) - DIFF_W'(from_z);

    // stage B: octant pick
    assign a = dx_reg[DIFF_W-1] ? MAG_W'(-dx_reg) : MAG_W'(dx_reg);
    assign b = dz_reg[DIFF_W-1] ? MAG_W'(-dz_reg) : MAG_W'(dz_reg);

    always_comb
    begin
        n_next         = '0;
        d_next         = MAG_W'(1);
        ctrl_next.neg  = 1'b0;
        ctrl_next.base = DEG_0;
        if (dx_reg == '0)
        begin
            ctrl_next.base = dz_reg[DIFF_W-1] ? DEG_180 : DEG_0;
        end
        else if (dz_reg == '0)
        begin
            ctrl_next.base = dx_reg[DIFF_W-1] ? DEG_270 : DEG_90;
        end
        else if (!dx_reg[DIFF_W-1] && !dz_reg[DIFF_W-1])
        begin
            if (a < b)
            begin
                ctrl_next.base = DEG_0;   ctrl_next.neg = 1'b0; n_next = a; d_next = b;
            end
            else
            begin
                ctrl_next.base = DEG_90;  ctrl_next.neg = 1'b1; n_next = b; d_next = a;
            end
        end
        else if (!dx_reg[DIFF_W-1])
        begin
            if (b < a)
            begin
                ctrl_next.base = DEG_90;  ctrl_next.neg = 1'b0; n_next = b; d_next = a;
            end
            else
            begin
                ctrl_next.base = DEG_180; ctrl_next.neg = 1'b1; n_next = a; d_next = b;
            end
        end
        else if (dz_reg[DIFF_W-1])
        begin
            if (b < a)
            begin
                ctrl_next.base = DEG_270; ctrl_next.neg = 1'b1; n_next = b; d_next = a;
            end
            else
            begin
                ctrl_next.base = DEG_180; ctrl_next.neg = 1'b0; n_next = a; d_next = b;
            end
        end
        else
        begin
            if (b < a)
            begin
                ctrl_next.base = DEG_270; ctrl_next.neg = 1'b0; n_next = b; d_next = a;
            end
            else
            begin
                ctrl_next.base = DEG_360; ctrl_next.neg = 1'b1; n_next = a; d_next = b;
            end
        end
    end

    // stage C: numerator = min * 45deg; split for the restoring chain
    assign num = NUM_W'(n_reg) * NUM_W'(SCALE);

    always_comb
    begin
        div_next.valid = vb_reg;
        div_next.ctrl  = ctrl_reg;
        div_next.rem   = num[NUM_W-1:Q_W];
        div_next.low   = num[Q_W-1:0];
        div_next.div   = d_reg;
        div_next.quot  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
            div_reg <= '0;
        end
        else
        begin
            va_reg  <= req;
            vb_reg  <= va_reg;
            div_reg <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dz_reg   <= dz_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        ctrl_reg <= ctrl_next;
    end

    assign div_o = div_reg;

endmodule

### design/opa_div_cell.sv
// opa_div_cell: one restoring-division step; resolves one quotient bit.
// Depends on opa_pkg.
module opa_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  opa_pkg::opa_div_t cell_i,
    output opa_pkg::opa_div_t cell_o
);
    import opa_pkg::*;

    logic [MAG_W:0] trial;
    logic [MAG_W:0] diff;
    logic           fits;
    opa_div_t       cell_reg, cell_next;

    assign trial = {cell_i.rem, cell_i.low[Q_W-1]};
    assign diff  = trial - {1'b0, cell_i.div};
    assign fits  = (trial >= {1'b0, cell_i.div});

    always_comb
    begin
        cell_next       = cell_i;
        cell_next.rem   = fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        cell_next.low   = {cell_i.low[Q_W-2:0], 1'b0};
        cell_next.quot  = {cell_i.quot[Q_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else
            cell_reg <= cell_next;
    end

    assign cell_o = cell_reg;

endmodule

### design/opa_finish.sv
// opa_finish: applies the quotient to the octant base, wraps a full turn
// and registers the result with its strobe. Depends on opa_pkg.
module opa_finish (
    input  logic                           clk,
    input  logic                           rst_n,
    input  opa_pkg::opa_div_t              div_i,
    output logic                           done,
    output logic [opa_pkg::BEARING_W-1:0]  bearing
);
    import opa_pkg::*;

    logic [BEARING_W-1:0] q_ext;
    logic [BEARING_W-1:0] raw;
    logic [BEARING_W-1:0] bearing_reg, bearing_next;
    logic                 done_reg;

    assign q_ext = BEARING_W'(div_i.quot);
    assign raw   = div_i.ctrl.neg ? (div_i.ctrl.base - q_ext)
                                  : (div_i.ctrl.base + q_ext);
    // last octant with zero quotient lands on 360: wrap to 0
    assign bearing_next = (raw >= DEG_360) ? (raw - DEG_360) : raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_i.valid;
    end

    always_ff @(posedge clk)
    begin
        bearing_reg <= bearing_next;
    end

    assign done    = done_reg;
    assign bearing = bearing_reg;

endmodule

### design/octant_pseudo_angle.sv
// octant_pseudo_angle: top level of the pseudo-angle bearing pipeline.
// Depends on opa_pkg, opa_octant, opa_div_cell, opa_finish.
//
//  channel   handshake          payload                         dir
//  -------   ----------------   -----------------------------   ---
//  request   start / busy       from_x from_z to_x to_z (s16)   in
//  result    done (1 cycle)     bearing (u17, 1/256 degree)     out
//
// One request per clock. The pipeline has
// three front stages (difference, octant pick, numerator multiply), one
// divider cell per quotient bit, one output register.
// busy is always low: the pipeline is fully registered and the chain of
// cells advances every cycle, so nothing ever waits.
// Reset clears all valid flags, so requests in flight at reset are dropped.
// The receiver cannot stall; done marks each result for one cycle only.
module octant_pseudo_angle (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [opa_pkg::COORD_BITS-1:0] from_x,
    input  logic signed [opa_pkg::COORD_BITS-1:0] from_z,
    input  logic signed [opa_pkg::COORD_BITS-1:0] to_x,
    input  logic signed [opa_pkg::COORD_BITS-1:0] to_z,
    output logic                                  done,
    output logic [opa_pkg::BEARING_W-1:0]         bearing
);
    import opa_pkg::*;

    // chain[0] feeds the first cell, chain[Q_W] leaves the last
    opa_div_t chain [Q_W+1];

    // the front end never stalls
    assign busy = 1'b0;

    opa_octant u_octant (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (start & ~busy),
        .from_x (from_x),
        .from_z (from_z),
        .to_x   (to_x),
        .to_z   (to_z),
        .div_o  (chain[0])
    );

    // one cell per quotient bit, MSB first
    for (genvar i = 0; i < Q_W; i++)
    begin : g_cell
        opa_div_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .cell_i (chain[i]),
            .cell_o (chain[i+1])
        );
    end

    opa_finish u_finish (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_i   (chain[Q_W]),
        .done    (done),
        .bearing (bearing)
    );

endmodule

### test/bearing_checker.sv
// bearing_checker: watches the request and result ports of octant_pseudo_angle,
// predicts each bearing and compares it with the result stream.
// Depends on opa_pkg for widths.
`timescale 1ns / 1ps

module bearing_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic signed [opa_pkg::COORD_BITS-1:0] from_x,
    input  logic signed [opa_pkg::COORD_BITS-1:0] from_z,
    input  logic signed [opa_pkg::COORD_BITS-1:0] to_x,
    input  logic signed [opa_pkg::COORD_BITS-1:0] to_z,
    input  logic                                  done,
    input  logic [opa_pkg::BEARING_W-1:0]         bearing,
    output int                                    errors,
    output int                                    pending
);
    import opa_pkg::*;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [BEARING_W-1:0]         bearing_t;

    bearing_t expected_bearings[$];
    int       mismatch_count = 0;

    assign errors = mismatch_count;

    function automatic longint deg(input int d);
        return longint'(d) << FRAC_BITS;
    endfunction

    // floor(n * 45deg / d) in fixed point
    function automatic longint octant_quotient(input longint n, input longint d);
        return (n * 45 * (longint'(1) << FRAC_BITS)) / d;
    endfunction

    function automatic bearing_t bearing_toward(input coord_t fx, input coord_t fz,
                                                input coord_t tx, input coord_t tz);
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dz;
        longint                   a;
        longint                   b;
        longint                   r;
        dx = tx - fx;
        dz = tz - fz;
        a  = (dx < 0) ? longint'(-dx) : longint'(dx);
        b  = (dz < 0) ? longint'(-dz) : longint'(dz);
        if (dx == 0)
            r = (dz < 0) ? deg(180) : 0;
        else if (dz == 0)
            r = (dx > 0) ? deg(90) : deg(270);
        else if (dx > 0 && dz > 0)
            r = (a < b) ? octant_quotient(a, b) : deg(90) - octant_quotient(b, a);
        else if (dx > 0)
            r = (b < a) ? deg(90) + octant_quotient(b, a) : deg(180) - octant_quotient(a, b);
        else if (dz < 0)
            r = (b < a) ? deg(270) - octant_quotient(b, a) : deg(180) + octant_quotient(a, b);
        else
            r = (b < a) ? deg(270) + octant_quotient(b, a) : deg(360) - octant_quotient(a, b);
        // last octant can truncate to a full turn
        if (r >= deg(360))
            r = r - deg(360);
        return bearing_t'(r);
    endfunction

    task automatic report_mismatch(input string what, input bearing_t got, input bearing_t want);
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // results first: a new request can never come out on the same edge
            if (done)
            begin
                if (expected_bearings.size() == 0)
                    report_mismatch("unexpected result", bearing, '0);
                else
                begin
                    bearing_t want;
                    want = expected_bearings.pop_front();
                    if (bearing !== want)
                        report_mismatch("bearing", bearing, want);
                end
            end
            if (start && !busy)
                expected_bearings.push_back(bearing_toward(from_x, from_z, to_x, to_z));
            pending <= expected_bearings.size();
        end
    end

endmodule

### test/testbench.sv
// testbench: stimulus and verdict for octant_pseudo_angle.
// Depends on opa_pkg, the design files and bearing_checker.
`timescale 1ns / 1ps

module testbench;
    import opa_pkg::*;

    // pipeline depth, from the stages listed at the head of the block
    localparam int PIPE_DEPTH  = 3 + Q_W + 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 500;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    coord_t   from_x = '0;
    coord_t   from_z = '0;
    coord_t   to_x = '0;
    coord_t   to_z = '0;
    logic     done;
    logic [BEARING_W-1:0] bearing;

    int errors;
    int pending;
    int cycle_count = 0;
    int idle_pct = 0;

    always #5 clk = ~clk;

    octant_pseudo_angle dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .from_x  (from_x),
        .from_z  (from_z),
        .to_x    (to_x),
        .to_z    (to_z),
        .done    (done),
        .bearing (bearing)
    );

    bearing_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .from_x  (from_x),
        .from_z  (from_z),
        .to_x    (to_x),
        .to_z    (to_z),
        .done    (done),
        .bearing (bearing),
        .errors  (errors),
        .pending (pending)
    );

    // watchdog: a hang anywhere ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // One request: random idle cycles first (start low), then hold start
    // high until an edge sees busy low. Inputs change only at rising edges.
    task automatic send_request(input coord_t fx, input coord_t fz,
                                input coord_t tx, input coord_t tz);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        from_x <= fx;
        from_z <= fz;
        to_x   <= tx;
        to_z   <= tz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // hold off until every outstanding bearing has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Random point pairs. Mix of fully random coordinates (every bit toggles),
    // short hops, near-axis, near-diagonal and long shallow pairs so all octant
    // edges and the small-quotient region get traffic. Sums wrap to 16 bits,
    // which is fine: the checker predicts from the values actually driven.
    task automatic send_random();
        coord_t fx;
        coord_t fz;
        int     ddx;
        int     ddz;
        fx = coord_t'($urandom);
        fz = coord_t'($urandom);
        case ($urandom_range(4))
            0:
            begin
                send_request(fx, fz, coord_t'($urandom), coord_t'($urandom));
                return;
            end
            1:
            begin
                ddx = int'($urandom_range(128)) - 64;
                ddz = int'($urandom_range(128)) - 64;
            end
            2:
            begin
                // one delta zero or tiny, the other anywhere
                ddx = int'($urandom_range(6)) - 3;
                ddz = int'($urandom_range(65535)) - 32768;
                if ($urandom_range(1))
                begin
                    int t;
                    t   = ddx;
                    ddx = ddz;
                    ddz = t;
                end
            end
            3:
            begin
                // |dx| close to |dz|
                ddx = int'($urandom_range(32767)) - 16384;
                ddz = ($urandom_range(1) ? ddx : -ddx) + int'($urandom_range(4)) - 2;
            end
            default:
            begin
                // long shallow vectors: quotient truncates to zero, one or two
                ddx = int'($urandom_range(3)) - 1;
                ddz = int'($urandom_range(32767, 11000));
                if ($urandom_range(1))
                    ddz = -ddz;
                if ($urandom_range(1))
                begin
                    int t;
                    t   = ddx;
                    ddx = ddz;
                    ddz = t;
                end
            end
        endcase
        send_request(fx, fz, coord_t'(int'(fx) + ddx), coord_t'(int'(fz) + ddz));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests, back to back.
        idle_pct = 0;
        // coincident points
        send_request(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        // the four axis directions
        send_request(16'sd0, 16'sd0, 16'sd0, 16'sd100);
        send_request(16'sd0, 16'sd0, 16'sd0, -16'sd100);
        send_request(16'sd0, 16'sd0, 16'sd100, 16'sd0);
        send_request(16'sd0, 16'sd0, -16'sd100, 16'sd0);
        // exact diagonals: 45, 135, 225, 315
        send_request(16'sd0, 16'sd0, 16'sd7, 16'sd7);
        send_request(16'sd0, 16'sd0, 16'sd7, -16'sd7);
        send_request(16'sd0, 16'sd0, -16'sd7, -16'sd7);
        send_request(16'sd0, 16'sd0, -16'sd7, 16'sd7);
        // one sample in each of the eight octants
        send_request(16'sd0, 16'sd0, 16'sd3, 16'sd10);
        send_request(16'sd0, 16'sd0, 16'sd10, 16'sd3);
        send_request(16'sd0, 16'sd0, 16'sd10, -16'sd3);
        send_request(16'sd0, 16'sd0, 16'sd3, -16'sd10);
        send_request(16'sd0, 16'sd0, -16'sd3, -16'sd10);
        send_request(16'sd0, 16'sd0, -16'sd10, -16'sd3);
        send_request(16'sd0, 16'sd0, -16'sd10, 16'sd3);
        send_request(16'sd0, 16'sd0, -16'sd3, 16'sd10);
        // full-range differences, both ways, and corner to corner
        send_request(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        send_request(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
        send_request(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
        send_request(-16'sd32768, 16'sd0, 16'sd32767, 16'sd1);
        send_request(-16'sd32768, -16'sd32768, -16'sd32767, 16'sd32767);
        // last octant, quotient truncates to zero: wraps to bearing 0
        send_request(16'sd0, 16'sd0, -16'sd1, 16'sd20000);
        // first octant, quotient truncates to zero
        send_request(16'sd0, 16'sd0, 16'sd1, 16'sd20000);

        // Random phase 1: sender idles about 29% of cycles.
        idle_pct = 29;
        repeat (PHASE_ITEMS) send_random();
        wait_drained();

        // Random phase 2: sender idles about 45% of cycles.
        idle_pct = 45;
        repeat (PHASE_ITEMS) send_random();
        wait_drained();

        // Random phase 3: back to back, no idling.
        idle_pct = 0;
        repeat (PHASE_ITEMS) send_random();

        // drain, then give the pipe time to show any stray result
        wait_drained();
        repeat (PIPE_DEPTH + 4) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
design/opa_pkg.sv
design/opa_octant.sv
design/opa_div_cell.sv
design/opa_finish.sv
design/octant_pseudo_angle.sv
test/bearing_checker.sv
test/testbench.sv
